[rtl/core/tspi_pkg.sv]
// Shared widths, types and lookup functions for the track sensor pair index block.
package tspi_pkg;

  // Field and datapath widths
  localparam int ZW      = 22;          // input coordinate and plane z width
  localparam int DFW     = ZW + 1;      // coordinate difference width
  localparam int PW      = 2 * DFW;     // product width
  localparam int PITCH_W = 20;          // pitch register width
  localparam int NW      = 48;          // divider numerator / quotient width
  localparam int DW      = 24;          // divider divisor / remainder width
  localparam int LANES   = 4;           // divider lanes per chain

  // Register reset values
  localparam int FIRST_Z_RESET      = 158920;
  localparam int LAST_Z_RESET       = -136080;
  localparam int SENSOR_PITCH_RESET = 41360;
  localparam int LADDER_PITCH_RESET = 72000;

  // Detector geometry
  localparam int ENTRY_LADDERS   = 6;
  localparam int ENTRY_MAX_CNT   = 15;
  localparam int EXIT_PER_LADDER = 11;
  localparam int EXIT_LADDER_MAX = 3;
  localparam int EXIT_LADDER_NEG = 4;
  localparam int PAIR_MULT       = 100;

  localparam logic [3:0] ENTRY_COUNT [ENTRY_LADDERS] = '{4'd15, 4'd15, 4'd15, 4'd15, 4'd14, 4'd13};

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_FIRST_Z      = 2'd0,
    CFG_LAST_Z       = 2'd1,
    CFG_SENSOR_PITCH = 2'd2,
    CFG_LADDER_PITCH = 2'd3
  } cfg_idx_t;

  // One divider cell's state: partial remainder, numerator/quotient shift word, divisor
  typedef struct packed {
    logic [DW-1:0] rem;
    logic [NW-1:0] nq;
    logic [DW-1:0] den;
  } div_t;

  // Sensors on an entry ladder
  function automatic logic [3:0] entry_count(input logic [2:0] l);
    logic [3:0] c;
    c = 4'd0;
    for (int i = 0; i < ENTRY_LADDERS; i++) begin
      if (l == 3'(i)) c = ENTRY_COUNT[i];
    end
    return c;
  endfunction

  // Running sum of the sensor counts of the ladders below l
  function automatic logic [6:0] entry_base(input logic [2:0] l);
    logic [6:0] s;
    s = 7'd0;
    for (int i = 0; i < ENTRY_LADDERS; i++) begin
      if (3'(i) < l) s = s + 7'(ENTRY_COUNT[i]);
    end
    return s;
  endfunction

  // Known bad entry/exit sensor pairs
  function automatic logic bad_pair(input logic [6:0] e, input logic [7:0] x);
    return (e == 7'd59 && x == 8'd98) || (e == 7'd59 && x == 8'd109) ||
           (e == 7'd73 && x == 8'd98) || (e == 7'd86 && x == 8'd97) ||
           (e == 7'd86 && x == 8'd98) || (e == 7'd97 && x == 8'd98);
  endfunction

endpackage

[rtl/core/tspi_div_cell.sv]
// One restoring-division cell: produces one quotient bit per cycle.
module tspi_div_cell (
  input  logic            clk,
  input  logic            en,
  input  tspi_pkg::div_t  d_in,
  output tspi_pkg::div_t  d_out
);

  tspi_pkg::div_t          cell_r;
  tspi_pkg::div_t          cell_nxt;
  logic [tspi_pkg::DW:0]   trial;
  logic [tspi_pkg::DW:0]   diff;

  // shift in the next numerator bit, subtract the divisor when it fits
  always_comb begin
    trial        = {d_in.rem, d_in.nq[tspi_pkg::NW-1]};
    diff         = trial - {1'b0, d_in.den};
    cell_nxt.den = d_in.den;
    if (trial >= {1'b0, d_in.den}) begin
      cell_nxt.rem = diff[tspi_pkg::DW-1:0];
      cell_nxt.nq  = {d_in.nq[tspi_pkg::NW-2:0], 1'b1};
    end else begin
      cell_nxt.rem = trial[tspi_pkg::DW-1:0];
      cell_nxt.nq  = {d_in.nq[tspi_pkg::NW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign d_out = cell_r;

endmodule

[rtl/core/tspi_div_chain.sv]
// Row of division cells forming one fully pipelined unsigned divider lane.
module tspi_div_chain (
  input  logic            clk,
  input  logic            en,
  input  tspi_pkg::div_t  d_in,
  output tspi_pkg::div_t  d_out
);

  tspi_pkg::div_t link [tspi_pkg::NW+1];

  assign link[0] = d_in;

  // one cell per quotient bit, MSB first
  for (genvar g = 0; g < tspi_pkg::NW; g++) begin : g_cell
    tspi_div_cell u_cell (
      .clk   (clk),
      .en    (en),
      .d_in  (link[g]),
      .d_out (link[g+1])
    );
  end

  assign d_out = link[tspi_pkg::NW];

endmodule

[rtl/core/track_sensor_pair_index_top.sv]
// Top level of the track sensor pair index block: projection, divider chains, lookup.
//
// Input channel (in_*): one track per transfer, two points in signed micrometres.
// A transfer happens when in_valid is high and in_stall is low.
// Result channel (out_*): one result per track, in order; a transfer happens when
// out_valid is high and out_stall is low. out_found low forces the indexes to zero.
// Configuration (cfg_*): register writes with cfg_valid/cfg_ready, cfg_ready is
// always high; write only while no track is in flight.
// Path from the input transfer to out_valid: three setup stages (difference,
// multiply, magnitude), a 48-cell divider chain by dz, two stages of floor
// correction and mirroring, a 48-cell divider chain by the pitches, one
// range-check stage and the output register.
// Throughput: one track per cycle while in_stall is low, set by the one-bit-per-cell divider chains.
// Stall: the output register is backed by a skid register; when out_stall holds
// a result, the next result lands in the skid and in_stall rises with it,
// freezing the whole pipeline until the result moves on.
// Reset: rst_n low clears all valid bits and loads the default geometry registers.
module track_sensor_pair_index_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [tspi_pkg::ZW-1:0] in_first_x,
  input  logic signed [tspi_pkg::ZW-1:0] in_first_y,
  input  logic signed [tspi_pkg::ZW-1:0] in_first_z,
  input  logic signed [tspi_pkg::ZW-1:0] in_second_x,
  input  logic signed [tspi_pkg::ZW-1:0] in_second_y,
  input  logic signed [tspi_pkg::ZW-1:0] in_second_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_found,
  output logic [6:0]                    out_entry_sensor,
  output logic [7:0]                    out_exit_sensor,
  output logic [14:0]                   out_pair_code,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [tspi_pkg::ZW-1:0]       cfg_data
);

  localparam int ZW    = tspi_pkg::ZW;
  localparam int DFW   = tspi_pkg::DFW;
  localparam int PW    = tspi_pkg::PW;
  localparam int NW    = tspi_pkg::NW;
  localparam int DW    = tspi_pkg::DW;
  localparam int PCW   = tspi_pkg::PITCH_W;
  localparam int LANES = tspi_pkg::LANES;

  // first chain lanes
  localparam int LN_X1 = 0;
  localparam int LN_Y1 = 1;
  localparam int LN_X9 = 2;
  localparam int LN_Y9 = 3;
  // second chain lanes
  localparam int LN_S1 = 0;
  localparam int LN_L1 = 1;
  localparam int LN_S9 = 2;
  localparam int LN_L9 = 3;

  typedef struct packed {
    logic signed [ZW-1:0] ax;
    logic signed [ZW-1:0] ay;
    logic [LANES-1:0]     neg;
    logic                 bad;
  } sb1_t;

  typedef struct packed {
    logic neg_s9;
    logic neg_l9;
    logic bad;
  } sb2_t;

  typedef struct packed {
    logic       found;
    logic [6:0] entry;
    logic [7:0] exit_idx;
    logic [14:0] code;
  } res_t;

  // configuration registers
  logic signed [ZW-1:0] first_z_r;
  logic signed [ZW-1:0] last_z_r;
  logic [PCW-1:0]       sp_r;
  logic [PCW-1:0]       lp_r;

  logic pipe_en;
  logic in_accept;

  // stage 1: differences
  logic                  p1_valid_r;
  logic signed [DFW-1:0] p1_dx_r, p1_dy_r, p1_dz_r, p1_t1_r, p1_t9_r;
  logic signed [ZW-1:0]  p1_ax_r, p1_ay_r;

  // stage 2: products
  logic                  p2_valid_r;
  logic signed [PW-1:0]  p2_prod_r [LANES];
  logic signed [DFW-1:0] p2_dz_r;
  logic signed [ZW-1:0]  p2_ax_r, p2_ay_r;

  // stage 3: magnitudes into the first chain
  logic           p3_valid_r;
  tspi_pkg::div_t p3_div_r [LANES];
  sb1_t           p3_sb_r;

  logic [NW-1:0]  v1_r;
  sb1_t           sb1_r [NW];
  tspi_pkg::div_t c1_out [LANES];

  // stage 4: projected coordinates
  logic                 p4_valid_r;
  logic signed [NW-1:0] p4_crd_r [LANES];
  logic                 p4_bad_r;
  logic signed [NW-1:0] p4_crd_nxt [LANES];

  // stage 5: mirrored magnitudes into the second chain
  logic           p5_valid_r;
  tspi_pkg::div_t p5_div_r [LANES];
  sb2_t           p5_sb_r;
  logic [NW-1:0]  mag_x1, mag_y1, mag_x9, mag_y9;

  logic [NW-1:0]  v2_r;
  sb2_t           sb2_r [NW];
  tspi_pkg::div_t c2_out [LANES];

  // stage 6: range-checked ladder and sensor numbers
  logic              p6_valid_r;
  logic [2:0]        p6_l1_r;
  logic [3:0]        p6_s1_r;
  logic signed [3:0] p6_l9_r;
  logic signed [4:0] p6_s9_r;
  logic              p6_ok_r;
  logic              l1_ok, s1_ok, l9_ok, s9_ok;
  logic              rnz_l9, rnz_s9;
  logic [3:0]        l9_nxt;
  logic [4:0]        s9_nxt;

  // result assembly and output/skid registers
  res_t       res_nxt;
  logic [6:0] e_idx;
  logic [3:0] x_lad;
  logic [3:0] x_sen;
  logic [7:0] x_idx;
  logic       res_ok;
  logic       out_valid_r, skid_valid_r;
  logic       out_valid_nxt, skid_valid_nxt;
  res_t       out_r, skid_r, out_nxt, skid_nxt;
  logic       out_take;

  assign cfg_ready = 1'b1;
  assign pipe_en   = !skid_valid_r;
  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !in_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_z_r <= ZW'(tspi_pkg::FIRST_Z_RESET);
      last_z_r  <= ZW'(tspi_pkg::LAST_Z_RESET);
      sp_r      <= PCW'(tspi_pkg::SENSOR_PITCH_RESET);
      lp_r      <= PCW'(tspi_pkg::LADDER_PITCH_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (tspi_pkg::cfg_idx_t'(cfg_index))
        tspi_pkg::CFG_FIRST_Z:      first_z_r <= cfg_data;
        tspi_pkg::CFG_LAST_Z:       last_z_r  <= cfg_data;
        tspi_pkg::CFG_SENSOR_PITCH: sp_r      <= cfg_data[PCW-1:0];
        tspi_pkg::CFG_LADDER_PITCH: lp_r      <= cfg_data[PCW-1:0];
        default: ;
      endcase
    end
  end

  // valid bits of the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
      p2_valid_r <= 1'b0;
      p3_valid_r <= 1'b0;
      v1_r       <= '0;
      p4_valid_r <= 1'b0;
      p5_valid_r <= 1'b0;
      v2_r       <= '0;
      p6_valid_r <= 1'b0;
    end else if (pipe_en) begin
      p1_valid_r <= in_accept;
      p2_valid_r <= p1_valid_r;
      p3_valid_r <= p2_valid_r;
      v1_r       <= {v1_r[NW-2:0], p3_valid_r};
      p4_valid_r <= v1_r[NW-1];
      p5_valid_r <= p4_valid_r;
      v2_r       <= {v2_r[NW-2:0], p5_valid_r};
      p6_valid_r <= v2_r[NW-1];
    end
  end

  // stages 1 to 3: differences, products, magnitudes
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      p1_dx_r <= {in_second_x[ZW-1], in_second_x} - {in_first_x[ZW-1], in_first_x};
      p1_dy_r <= {in_second_y[ZW-1], in_second_y} - {in_first_y[ZW-1], in_first_y};
      p1_dz_r <= {in_second_z[ZW-1], in_second_z} - {in_first_z[ZW-1], in_first_z};
      p1_t1_r <= {first_z_r[ZW-1], first_z_r} - {in_first_z[ZW-1], in_first_z};
      p1_t9_r <= {last_z_r[ZW-1], last_z_r} - {in_first_z[ZW-1], in_first_z};
      p1_ax_r <= in_first_x;
      p1_ay_r <= in_first_y;

      p2_prod_r[LN_X1] <= p1_dx_r * p1_t1_r;
      p2_prod_r[LN_Y1] <= p1_dy_r * p1_t1_r;
      p2_prod_r[LN_X9] <= p1_dx_r * p1_t9_r;
      p2_prod_r[LN_Y9] <= p1_dy_r * p1_t9_r;
      p2_dz_r          <= p1_dz_r;
      p2_ax_r          <= p1_ax_r;
      p2_ay_r          <= p1_ay_r;

      for (int k = 0; k < LANES; k++) begin
        p3_div_r[k].rem <= '0;
        p3_div_r[k].nq  <= {{(NW-PW){1'b0}},
                            (p2_prod_r[k][PW-1] ? -p2_prod_r[k] : p2_prod_r[k])};
        p3_div_r[k].den <= {{(DW-DFW){1'b0}}, (p2_dz_r[DFW-1] ? -p2_dz_r : p2_dz_r)};
        p3_sb_r.neg[k]  <= p2_prod_r[k][PW-1] ^ p2_dz_r[DFW-1];
      end
      p3_sb_r.ax  <= p2_ax_r;
      p3_sb_r.ay  <= p2_ay_r;
      p3_sb_r.bad <= (p2_dz_r == '0) || (sp_r == '0) || (lp_r == '0);
    end
  end

  // first divider chain: products by dz
  for (genvar g = 0; g < LANES; g++) begin : g_c1
    tspi_div_chain u_chain (
      .clk   (clk),
      .en    (pipe_en),
      .d_in  (p3_div_r[g]),
      .d_out (c1_out[g])
    );
  end

  // sideband line alongside the first chain
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sb1_r[0] <= p3_sb_r;
      for (int i = 1; i < NW; i++) begin
        sb1_r[i] <= sb1_r[i-1];
      end
    end
  end

  // stage 4: floor correction folded into the add of the start point
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      logic [NW:0] base;
      logic [NW:0] qext;
      logic [NW:0] sum;
      base = (k == LN_X1 || k == LN_X9) ?
             {{(NW+1-ZW){sb1_r[NW-1].ax[ZW-1]}}, sb1_r[NW-1].ax} :
             {{(NW+1-ZW){sb1_r[NW-1].ay[ZW-1]}}, sb1_r[NW-1].ay};
      qext = {1'b0, c1_out[k].nq};
      if (sb1_r[NW-1].neg[k]) begin
        sum = base - qext - (NW+1)'(|c1_out[k].rem);
      end else begin
        sum = base + qext;
      end
      p4_crd_nxt[k] = sum[NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int k = 0; k < LANES; k++) begin
        p4_crd_r[k] <= p4_crd_nxt[k];
      end
      p4_bad_r <= sb1_r[NW-1].bad;
    end
  end

  // stage 5: mirror by the entry signs and set up the pitch divisions
  assign mag_x1 = p4_crd_r[LN_X1][NW-1] ? -p4_crd_r[LN_X1] : p4_crd_r[LN_X1];
  assign mag_y1 = p4_crd_r[LN_Y1][NW-1] ? -p4_crd_r[LN_Y1] : p4_crd_r[LN_Y1];
  assign mag_x9 = p4_crd_r[LN_X9][NW-1] ? -p4_crd_r[LN_X9] : p4_crd_r[LN_X9];
  assign mag_y9 = p4_crd_r[LN_Y9][NW-1] ? -p4_crd_r[LN_Y9] : p4_crd_r[LN_Y9];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int k = 0; k < LANES; k++) begin
        p5_div_r[k].rem <= '0;
      end
      p5_div_r[LN_S1].nq  <= mag_x1;
      p5_div_r[LN_S1].den <= {{(DW-PCW){1'b0}}, sp_r};
      p5_div_r[LN_L1].nq  <= {mag_y1[NW-2:0], 1'b0} + {{(NW-PCW){1'b0}}, lp_r};
      p5_div_r[LN_L1].den <= {{(DW-PCW-1){1'b0}}, lp_r, 1'b0};
      p5_div_r[LN_S9].nq  <= mag_x9;
      p5_div_r[LN_S9].den <= {{(DW-PCW){1'b0}}, sp_r};
      p5_div_r[LN_L9].nq  <= mag_y9;
      p5_div_r[LN_L9].den <= {{(DW-PCW){1'b0}}, lp_r};
      p5_sb_r.neg_s9 <= p4_crd_r[LN_X9][NW-1] ^ p4_crd_r[LN_X1][NW-1];
      p5_sb_r.neg_l9 <= p4_crd_r[LN_Y9][NW-1] ^ p4_crd_r[LN_Y1][NW-1];
      p5_sb_r.bad    <= p4_bad_r;
    end
  end

  // second divider chain: coordinates by the pitches
  for (genvar g = 0; g < LANES; g++) begin : g_c2
    tspi_div_chain u_chain (
      .clk   (clk),
      .en    (pipe_en),
      .d_in  (p5_div_r[g]),
      .d_out (c2_out[g])
    );
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sb2_r[0] <= p5_sb_r;
      for (int i = 1; i < NW; i++) begin
        sb2_r[i] <= sb2_r[i-1];
      end
    end
  end

  // stage 6: floor correction and range checks on the quotients
  always_comb begin
    rnz_l9 = |c2_out[LN_L9].rem;
    rnz_s9 = |c2_out[LN_S9].rem;
    l1_ok  = c2_out[LN_L1].nq < NW'(tspi_pkg::ENTRY_LADDERS);
    s1_ok  = c2_out[LN_S1].nq < NW'(tspi_pkg::ENTRY_MAX_CNT);
    // negative side: -(q) - carry must stay at or above the lower limit
    if (sb2_r[NW-1].neg_l9) begin
      l9_ok  = (c2_out[LN_L9].nq < NW'(tspi_pkg::EXIT_LADDER_NEG)) ||
               (c2_out[LN_L9].nq == NW'(tspi_pkg::EXIT_LADDER_NEG) && !rnz_l9);
      l9_nxt = rnz_l9 ? ~c2_out[LN_L9].nq[3:0] : -c2_out[LN_L9].nq[3:0];
    end else begin
      l9_ok  = c2_out[LN_L9].nq <= NW'(tspi_pkg::EXIT_LADDER_MAX);
      l9_nxt = c2_out[LN_L9].nq[3:0];
    end
    if (sb2_r[NW-1].neg_s9) begin
      s9_ok  = (c2_out[LN_S9].nq < NW'(tspi_pkg::EXIT_PER_LADDER)) ||
               (c2_out[LN_S9].nq == NW'(tspi_pkg::EXIT_PER_LADDER) && !rnz_s9);
      s9_nxt = rnz_s9 ? ~c2_out[LN_S9].nq[4:0] : -c2_out[LN_S9].nq[4:0];
    end else begin
      s9_ok  = c2_out[LN_S9].nq < NW'(tspi_pkg::EXIT_PER_LADDER);
      s9_nxt = c2_out[LN_S9].nq[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      p6_l1_r <= c2_out[LN_L1].nq[2:0];
      p6_s1_r <= c2_out[LN_S1].nq[3:0];
      p6_l9_r <= l9_nxt;
      p6_s9_r <= s9_nxt;
      p6_ok_r <= !sb2_r[NW-1].bad && l1_ok && s1_ok && l9_ok && s9_ok;
    end
  end

  // entry and exit indexes, bad pair veto
  always_comb begin
    e_idx = tspi_pkg::entry_base(p6_l1_r) + {3'b0, p6_s1_r};
    if (!p6_s9_r[4]) begin
      x_lad = 4'(tspi_pkg::EXIT_PER_LADDER) - p6_l9_r;
      x_sen = p6_s9_r[3:0];
    end else begin
      x_lad = p6_l9_r + 4'(tspi_pkg::EXIT_LADDER_NEG);
      x_sen = ~p6_s9_r[3:0];
    end
    x_idx  = {4'b0, x_lad} * 8'(tspi_pkg::EXIT_PER_LADDER) + {4'b0, x_sen};
    res_ok = p6_ok_r && (p6_s1_r < tspi_pkg::entry_count(p6_l1_r)) &&
             !tspi_pkg::bad_pair(e_idx, x_idx);
    res_nxt.found    = res_ok;
    res_nxt.entry    = res_ok ? e_idx : 7'd0;
    res_nxt.exit_idx = res_ok ? x_idx : 8'd0;
    res_nxt.code     = res_ok ? 15'(x_idx) * 15'(tspi_pkg::PAIR_MULT) + 15'(e_idx) : 15'd0;
  end

  // output register with skid backup
  assign out_take = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (out_take) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r || out_take) begin
      out_valid_nxt = p6_valid_r;
      out_nxt       = res_nxt;
    end else if (p6_valid_r) begin
      skid_nxt       = res_nxt;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_r.found;
  assign out_entry_sensor = out_r.entry;
  assign out_exit_sensor  = out_r.exit_idx;
  assign out_pair_code    = out_r.code;

`ifndef ASSERT_OFF
  // a held skid entry always sits behind a valid output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result while the output is empty");

  // a miss carries all-zero indexes
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |->
      (out_entry_sensor == 7'd0 && out_exit_sensor == 8'd0 && out_pair_code == 15'd0))
    else $error("not-found result carries nonzero indexes");

  // a hit stays within the sensor index ranges
  a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_entry_sensor <= 7'd86 && out_exit_sensor <= 8'd175))
    else $error("found result has an index out of range");
`endif

endmodule
